### hdl/mbd_pkg.sv
// Shared constants, codes and types of the mipmap box downsampler.
package mbd_pkg;

	localparam int BYTE_W = 8;
	localparam int LANES = 4;
	localparam int LANE_W = 9;
	localparam int PAIR_W = LANES * LANE_W;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int DIM_W = 13;
	localparam int CHAN_CNT_W = 3;
	localparam int LINE_ADDR_W = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int RESET_DIM = 256;
	localparam int RESET_BPP = 4;

	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t CFG_SRC_WIDTH = CFG_ADDR_W'(0);
	localparam cfg_addr_t CFG_SRC_HEIGHT = CFG_ADDR_W'(1);
	localparam cfg_addr_t CFG_BYTES_PER_PIXEL = CFG_ADDR_W'(2);

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_EMIT,
		OP_EMIT_LINE
	} mbd_op_t;

	typedef struct packed {
		mbd_op_t op;
		logic [LINE_ADDR_W-1:0] addr;
		logic [PAIR_W-1:0] sum;
		logic [PAIR_W-1:0] other;
		logic [1:0] shift;
		logic last;
	} mbd_job_t;

endpackage

### hdl/mbd_ifs.sv
// Handshake interfaces for the pixel, result and register write channels.
interface mbd_pix_if import mbd_pkg::*; ();
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] channel_0;
	logic [BYTE_W-1:0] channel_1;
	logic [BYTE_W-1:0] channel_2;
	logic [BYTE_W-1:0] channel_3;

	modport source(output valid, channel_0, channel_1, channel_2, channel_3, input ready);
	modport sink(input valid, channel_0, channel_1, channel_2, channel_3, output ready);
endinterface

interface mbd_res_if import mbd_pkg::*; ();
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] out_channel_0;
	logic [BYTE_W-1:0] out_channel_1;
	logic [BYTE_W-1:0] out_channel_2;
	logic [BYTE_W-1:0] out_channel_3;
	logic frame_end;

	modport source(output valid, out_channel_0, out_channel_1, out_channel_2, out_channel_3,
		frame_end, input ready);
	modport sink(input valid, out_channel_0, out_channel_1, out_channel_2, out_channel_3,
		frame_end, output ready);
endinterface

interface mbd_cfg_if import mbd_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

### hdl/mbd_front.sv
// Front end: register file, raster counters, pair accumulator and job classification.
module mbd_front import mbd_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input logic clk,
	input logic arst_n,
	mbd_pix_if.sink pixel,
	mbd_cfg_if.sink cfg,
	output logic job_valid,
	output mbd_job_t job,
	input logic job_ready
);

	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int W_RST = (RESET_DIM < MAX_WIDTH) ? RESET_DIM : MAX_WIDTH;
	localparam int N_RST = (RESET_BPP < MAX_CHANNELS) ? RESET_BPP : MAX_CHANNELS;

	logic [WCW-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [CHAN_CNT_W-1:0] n_q;
	logic [XW-1:0] x_q;
	logic [DIM_W-1:0] y_q;
	logic [PAIR_W-1:0] acc_q;

	logic [BYTE_W-1:0] chan [LANES];
	logic [PAIR_W-1:0] pix;
	logic [PAIR_W-1:0] pair_sum;
	logic wide;
	logic tall;
	logic last;
	logic accept;
	logic cfg_wr;
	logic cfg_hit;
	logic col_end;
	logic row_end;
	logic emit;
	logic acc_load;
	logic [WCW-1:0] ox;
	logic [WCW-1:0] ox_end;
	logic [DIM_W-1:0] oy;
	logic [DIM_W-1:0] oy_end;
	logic [WCW-1:0] w_clamp;
	logic [DIM_W-1:0] h_clamp;
	logic [CHAN_CNT_W-1:0] n_raw;
	logic [CHAN_CNT_W-1:0] n_clamp;

	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid && cfg.ready;
	assign pixel.ready = job_ready;
	assign accept = pixel.valid && pixel.ready;

	assign chan[0] = pixel.channel_0;
	assign chan[1] = pixel.channel_1;
	assign chan[2] = pixel.channel_2;
	assign chan[3] = pixel.channel_3;

	always_comb begin
		pix = '0;
		for (int c = 0; c < LANES; c++) begin
			if (CHAN_CNT_W'(c) < n_q) begin
				pix[c*LANE_W +: LANE_W] = LANE_W'(chan[c]);
			end
		end
	end

	assign pair_sum = acc_q + pix;
	assign wide = (w_q != WCW'(1));
	assign tall = (h_q != DIM_W'(1));
	assign ox = wide ? WCW'(x_q >> 1) : '0;
	assign ox_end = wide ? (w_q >> 1) - WCW'(1) : '0;
	assign oy = tall ? (y_q >> 1) : '0;
	assign oy_end = tall ? (h_q >> 1) - DIM_W'(1) : '0;
	assign last = (ox == ox_end) && (oy == oy_end);
	assign col_end = (WCW'(x_q) == w_q - WCW'(1));
	assign row_end = (y_q == h_q - DIM_W'(1));

	always_comb begin
		job.op = OP_EMIT;
		job.addr = LINE_ADDR_W'(x_q >> 1);
		job.sum = pix;
		job.other = acc_q;
		job.shift = 2'd1;
		job.last = last;
		emit = 1'b0;
		acc_load = 1'b0;
		if (!wide && !tall) begin
			emit = 1'b1;
			job.other = '0;
			job.shift = 2'd0;
		end else if (wide && tall) begin
			if (!x_q[0]) begin
				acc_load = 1'b1;
			end else begin
				emit = 1'b1;
				job.sum = pair_sum;
				job.shift = 2'd2;
				job.op = y_q[0] ? OP_EMIT_LINE : OP_WRITE;
			end
		end else if ((wide && !x_q[0]) || (!wide && !y_q[0])) begin
			acc_load = 1'b1;
		end else begin
			emit = 1'b1;
		end
	end

	assign job_valid = accept && emit;

	always_comb begin
		n_raw = cfg.data[CHAN_CNT_W-1:0];
		if (cfg.data == '0) begin
			w_clamp = WCW'(1);
			h_clamp = DIM_W'(1);
		end else begin
			w_clamp = (int'(cfg.data) > MAX_WIDTH) ? WCW'(MAX_WIDTH) : WCW'(cfg.data);
			h_clamp = DIM_W'(cfg.data);
		end
		if (n_raw == '0) begin
			n_clamp = CHAN_CNT_W'(1);
		end else if (int'(n_raw) > MAX_CHANNELS) begin
			n_clamp = CHAN_CNT_W'(MAX_CHANNELS);
		end else begin
			n_clamp = n_raw;
		end
		cfg_hit = (cfg.addr == CFG_SRC_WIDTH) || (cfg.addr == CFG_SRC_HEIGHT) ||
			(cfg.addr == CFG_BYTES_PER_PIXEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WCW'(W_RST);
			h_q <= DIM_W'(RESET_DIM);
			n_q <= CHAN_CNT_W'(N_RST);
			x_q <= '0;
			y_q <= '0;
			acc_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg.addr)
				CFG_SRC_WIDTH: begin
					w_q <= w_clamp;
				end
				CFG_SRC_HEIGHT: begin
					h_q <= h_clamp;
				end
				CFG_BYTES_PER_PIXEL: begin
					n_q <= n_clamp;
				end
				default: begin
				end
			endcase
			if (cfg_hit) begin
				x_q <= '0;
				y_q <= '0;
				acc_q <= '0;
			end
		end else if (accept) begin
			if (acc_load) begin
				acc_q <= pix;
			end
			x_q <= col_end ? '0 : x_q + XW'(1);
			if (col_end) begin
				y_q <= row_end ? '0 : y_q + DIM_W'(1);
			end
		end
	end

endmodule

### hdl/mbd_fifo.sv
// Short job queue that decouples the front end from the line store back end.
module mbd_fifo import mbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input mbd_job_t push_job,
	output logic push_ready,
	output logic pop_valid,
	output mbd_job_t pop_job,
	input logic pop_ready
);

	localparam int QPW = $clog2(QUEUE_DEPTH);

	mbd_job_t slot_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QPW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != (QPW+1)'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job = slot_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPW+1)'(1);
			end
		end
	end

endmodule

### hdl/mbd_back.sv
// Back end: even-row line store, averaging stage and output register.
module mbd_back import mbd_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input mbd_job_t job,
	output logic job_ready,
	mbd_res_if.source result
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PAIR_W-1:0] line_mem [DEPTH];
	logic [PAIR_W-1:0] rd_s1;
	mbd_job_t job_s1;
	logic valid_s1;
	logic [BYTE_W-1:0] out_chan_q [LANES];
	logic out_last_q;
	logic out_valid_q;

	logic [AW-1:0] addr;
	logic pop;
	logic out_load;
	logic s1_free;
	logic s1_adv;
	logic [PAIR_W-1:0] lhs;
	logic [LANE_W:0] lane_sum [LANES];
	logic [LANE_W:0] lane_shr [LANES];
	logic [BYTE_W-1:0] avg [LANES];

	assign out_load = !out_valid_q || result.ready;
	assign s1_adv = valid_s1 && out_load;
	assign s1_free = !valid_s1 || out_load;
	assign job_ready = s1_free;
	assign pop = job_valid && s1_free;
	assign addr = job.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			if (job.op == OP_WRITE) begin
				line_mem[addr] <= job.sum;
			end
			rd_s1 <= line_mem[addr];
			job_s1 <= job;
		end
	end

	always_comb begin
		lhs = (job_s1.op == OP_EMIT_LINE) ? rd_s1 : job_s1.other;
		for (int c = 0; c < LANES; c++) begin
			lane_sum[c] = (LANE_W+1)'(lhs[c*LANE_W +: LANE_W]) +
				(LANE_W+1)'(job_s1.sum[c*LANE_W +: LANE_W]);
			lane_shr[c] = lane_sum[c] >> job_s1.shift;
			avg[c] = lane_shr[c][BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_chan_q <= avg;
			out_last_q <= job_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pop && ((job.op == OP_EMIT) || (job.op == OP_EMIT_LINE));
			end
			if (out_load) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_channel_0 = out_chan_q[0];
	assign result.out_channel_1 = out_chan_q[1];
	assign result.out_channel_2 = out_chan_q[2];
	assign result.out_channel_3 = out_chan_q[3];
	assign result.frame_end = out_last_q;

endmodule

### hdl/mipmap_box_downsample_core.sv
// Top level of the 2x2 box filter that builds the next mipmap level from a pixel stream.
// A completing pixel passes the job queue, line store read stage and output register.
// Throughput: one pixel per cycle when not stalled, set by one line store access per job.
// The line store is read only where the even row above wrote it, so it is never cleared.
// Reset restores the registers to 256 x 256 with four bytes and clears counters and queue.
// A register write restarts the level at its first pixel.
module mipmap_box_downsample_core import mbd_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input logic clk,
	input logic arst_n,
	mbd_pix_if.sink pixel,
	mbd_res_if.source result,
	mbd_cfg_if.sink cfg
);

	logic front_valid;
	mbd_job_t front_job;
	logic front_ready;
	logic back_valid;
	mbd_job_t back_job;
	logic back_ready;

	mbd_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.cfg(cfg),
		.job_valid(front_valid),
		.job(front_job),
		.job_ready(front_ready)
	);

	mbd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_job(front_job),
		.push_ready(front_ready),
		.pop_valid(back_valid),
		.pop_job(back_job),
		.pop_ready(back_ready)
	);

	mbd_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(back_valid),
		.job(back_job),
		.job_ready(back_ready),
		.result(result)
	);

endmodule
